/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check with a fixed message.
`define BTPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("btpc assertion failed");

// Property check with a caller supplied message.
`define BTPC_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

/* hw/rtl/btpc_pkg.sv */
// Package for the barometric compensation block: constants, state type and
// the request and response structs between the sequencer and its units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btpc_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEFFS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_NINE   = 2'd3;

    localparam int unsigned RAW_W     = 20;
    localparam int unsigned DATA_W    = 64;
    localparam int unsigned DIV_STEPS = 64;

    localparam logic [63:0] OFFSET_FINE = 64'd128000;
    localparam logic [63:0] PRESS_FULL  = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [31:0] ROUND_HALF  = 32'd128;
    localparam logic [63:0] BIAS_47     = 64'h0000_8000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T_D1,
        ST_T_D2,
        ST_T_B,
        ST_T_FIN,
        ST_P_SETUP,
        ST_P_SQ,
        ST_P_M6,
        ST_P_M5,
        ST_P_M3,
        ST_P_M2,
        ST_P_M1,
        ST_P_CHK,
        ST_P_N,
        ST_P_DIV,
        ST_P_Q9,
        ST_P_Q9B,
        ST_P_Q8,
        ST_P_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } t_unit_rsp;

    typedef struct packed {
        logic        valid;
        logic        is_pressure;
        logic [31:0] temperature;
        logic [31:0] pressure;
        logic        div_zero;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/btpc_mul.sv */
// Iterative 64 x 64 multiplier returning the low 64 bits of the product.
// One 32 x 32 multiplier is reused for every partial product. Uses btpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btpc_mul
    import btpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_unit_req i_req,
    output t_unit_rsp      o_rsp
);

    logic        r_run;
    logic [1:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_pp;
    logic [63:0] r_acc;
    logic        r_done;
    logic [31:0] op_x;
    logic [31:0] op_y;

    // Partial products: low x low, low x high, high x low.
    assign op_x = (r_cnt == 2'd2) ? r_a[63:32] : r_a[31:0];
    assign op_y = (r_cnt == 2'd1) ? r_b[63:32] : r_b[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= 2'd0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_run) begin
            r_pp <= 64'(op_x) * 64'(op_y);
            case (r_cnt)
                2'd1:    r_acc <= r_pp;
                2'd2:    r_acc <= r_acc + {r_pp[31:0], 32'd0};
                2'd3:    r_acc <= r_acc + {r_pp[31:0], 32'd0};
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_acc;

endmodule

`default_nettype wire

/* hw/rtl/btpc_div.sv */
// Signed 64-bit divider, restoring, one quotient bit per cycle.
// Truncates toward zero; the divisor is never zero here. Uses btpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btpc_div
    import btpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_unit_req i_req,
    output t_unit_rsp      o_rsp
);

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    logic             r_run;
    logic             r_fix;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_rem;
    logic [63:0]      r_quo;
    logic [63:0]      r_den;
    logic             r_neg;
    logic [63:0]      r_res;
    logic [64:0]      shifted;
    logic [64:0]      diff;
    logic             qbit;

    assign shifted = {r_rem, r_quo[63]};
    assign diff    = shifted - {1'b0, r_den};
    assign qbit    = !diff[64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_run <= 1'b0;
                    r_fix <= 1'b1;
                end
            end else if (r_fix) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.a[63] ? (64'd0 - i_req.a) : i_req.a;
            r_den <= i_req.b[63] ? (64'd0 - i_req.b) : i_req.b;
            r_neg <= i_req.a[63] ^ i_req.b[63];
            r_rem <= 64'd0;
        end else if (r_run) begin
            r_rem <= qbit ? diff[63:0] : shifted[63:0];
            r_quo <= {r_quo[62:0], qbit};
        end else if (r_fix) begin
            r_res <= r_neg ? (64'd0 - r_quo) : r_quo;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_res;

endmodule

`default_nettype wire

/* hw/rtl/btpc_seq.sv */
// Sequencer that runs the temperature and pressure formulas through the
// shared multiplier and divider. Holds the fine temperature. Uses btpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btpc_seq
    import btpc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_op,
    input  wire logic [RAW_W-1:0] i_raw,
    input  wire logic [47:0]      i_tc,
    input  wire logic [63:0]      i_pl,
    input  wire logic [63:0]      i_ph,
    input  wire logic [15:0]      i_p9,
    input  wire logic             i_res_taken,
    output logic                  o_idle,
    output t_unit_req             o_mul_req,
    input  wire t_unit_rsp        i_mul_rsp,
    output t_unit_req             o_div_req,
    input  wire t_unit_rsp        i_div_rsp,
    output t_result               o_res
);

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    t_state r_state;
    t_state n_state;

    logic             r_wait;
    logic             r_op;
    logic [RAW_W-1:0] r_raw;
    logic [31:0]      r_ft;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_c;
    logic [31:0]      r_temp;
    logic [31:0]      r_press;
    logic             r_dz;

    logic        is_mul;
    logic [31:0] t1;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [31:0] ft_sum;
    logic [31:0] ft_x5;
    logic [63:0] q13;
    logic [63:0] prod;
    logic [63:0] fin_sum;

    assign t1     = {16'd0, i_tc[15:0]};
    assign d1     = 32'(r_raw >> 3) - (t1 << 1);
    assign d2     = 32'(r_raw >> 4) - t1;
    assign ft_sum = r_a[31:0] + r_b[31:0];
    assign ft_x5  = (ft_sum << 2) + ft_sum + ROUND_HALF;
    assign q13    = $signed(r_a) >>> 13;
    assign prod   = i_mul_rsp.value;
    assign fin_sum = r_a + r_b + r_c;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_accept) n_state = i_op ? ST_P_SETUP : ST_T_D1;
            ST_T_D1:    if (i_mul_rsp.done) n_state = ST_T_D2;
            ST_T_D2:    if (i_mul_rsp.done) n_state = ST_T_B;
            ST_T_B:     if (i_mul_rsp.done) n_state = ST_T_FIN;
            ST_T_FIN:   n_state = ST_OUT;
            ST_P_SETUP: n_state = ST_P_SQ;
            ST_P_SQ:    if (i_mul_rsp.done) n_state = ST_P_M6;
            ST_P_M6:    if (i_mul_rsp.done) n_state = ST_P_M5;
            ST_P_M5:    if (i_mul_rsp.done) n_state = ST_P_M3;
            ST_P_M3:    if (i_mul_rsp.done) n_state = ST_P_M2;
            ST_P_M2:    if (i_mul_rsp.done) n_state = ST_P_M1;
            ST_P_M1:    if (i_mul_rsp.done) n_state = ST_P_CHK;
            ST_P_CHK:   n_state = (r_a == 64'd0) ? ST_OUT : ST_P_N;
            ST_P_N:     if (i_mul_rsp.done) n_state = ST_P_DIV;
            ST_P_DIV:   if (i_div_rsp.done) n_state = ST_P_Q9;
            ST_P_Q9:    if (i_mul_rsp.done) n_state = ST_P_Q9B;
            ST_P_Q9B:   if (i_mul_rsp.done) n_state = ST_P_Q8;
            ST_P_Q8:    if (i_mul_rsp.done) n_state = ST_P_FIN;
            ST_P_FIN:   n_state = ST_OUT;
            ST_OUT:     if (i_res_taken) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        is_mul      = 1'b0;
        o_mul_req.a = 64'd0;
        o_mul_req.b = 64'd0;
        unique case (r_state)
            ST_T_D1:  begin is_mul = 1'b1; o_mul_req.a = {32'd0, d1};
                      o_mul_req.b = sx16(i_tc[31:16]); end
            ST_T_D2:  begin is_mul = 1'b1; o_mul_req.a = {32'd0, d2};
                      o_mul_req.b = {32'd0, d2}; end
            ST_T_B:   begin is_mul = 1'b1; o_mul_req.a = r_b;
                      o_mul_req.b = sx16(i_tc[47:32]); end
            ST_P_SQ:  begin is_mul = 1'b1; o_mul_req.a = r_a; o_mul_req.b = r_a; end
            ST_P_M6:  begin is_mul = 1'b1; o_mul_req.a = r_b;
                      o_mul_req.b = sx16(i_ph[31:16]); end
            ST_P_M5:  begin is_mul = 1'b1; o_mul_req.a = r_a;
                      o_mul_req.b = sx16(i_ph[15:0]); end
            ST_P_M3:  begin is_mul = 1'b1; o_mul_req.a = r_b;
                      o_mul_req.b = sx16(i_pl[47:32]); end
            ST_P_M2:  begin is_mul = 1'b1; o_mul_req.a = r_a;
                      o_mul_req.b = sx16(i_pl[31:16]); end
            ST_P_M1:  begin is_mul = 1'b1; o_mul_req.a = r_a;
                      o_mul_req.b = {48'd0, i_pl[15:0]}; end
            ST_P_N:   begin is_mul = 1'b1; o_mul_req.a = r_b; o_mul_req.b = PRESS_SCALE; end
            ST_P_Q9:  begin is_mul = 1'b1; o_mul_req.a = sx16(i_p9); o_mul_req.b = q13; end
            ST_P_Q9B: begin is_mul = 1'b1; o_mul_req.a = r_b; o_mul_req.b = q13; end
            ST_P_Q8:  begin is_mul = 1'b1; o_mul_req.a = sx16(i_ph[63:48]);
                      o_mul_req.b = r_a; end
            default:  is_mul = 1'b0;
        endcase
        o_mul_req.start = is_mul && !r_wait;
        o_div_req.start = (r_state == ST_P_DIV) && !r_wait;
        o_div_req.a     = r_b;
        o_div_req.b     = r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            r_ft    <= 32'd0;
        end else begin
            r_state <= n_state;
            if (o_mul_req.start || o_div_req.start) begin
                r_wait <= 1'b1;
            end else if (i_mul_rsp.done || i_div_rsp.done) begin
                r_wait <= 1'b0;
            end
            if (r_state == ST_T_FIN) begin
                r_ft <= ft_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_op  <= i_op;
                r_raw <= i_raw;
            end
            ST_T_D1: if (i_mul_rsp.done) r_a <= {32'd0, 32'($signed(prod[31:0]) >>> 11)};
            ST_T_D2: if (i_mul_rsp.done) r_b <= {32'd0, 32'($signed(prod[31:0]) >>> 12)};
            ST_T_B:  if (i_mul_rsp.done) r_b <= {32'd0, 32'($signed(prod[31:0]) >>> 14)};
            ST_T_FIN: begin
                r_temp  <= 32'($signed(ft_x5) >>> 8);
                r_press <= 32'd0;
                r_dz    <= 1'b0;
            end
            ST_P_SETUP: r_a <= {{32{r_ft[31]}}, r_ft} - OFFSET_FINE;
            ST_P_SQ: if (i_mul_rsp.done) r_b <= prod;
            ST_P_M6: if (i_mul_rsp.done) r_c <= prod;
            ST_P_M5: if (i_mul_rsp.done) r_c <= r_c + (prod << 17) + (sx16(i_pl[63:48]) << 35);
            ST_P_M3: if (i_mul_rsp.done) r_b <= $signed(prod) >>> 8;
            ST_P_M2: if (i_mul_rsp.done) r_a <= r_b + (prod << 12) + BIAS_47;
            ST_P_M1: if (i_mul_rsp.done) r_a <= $signed(prod) >>> 33;
            ST_P_CHK: begin
                r_b     <= ((PRESS_FULL - 64'(r_raw)) << 31) - r_c;
                r_temp  <= 32'd0;
                r_press <= 32'd0;
                r_dz    <= (r_a == 64'd0);
            end
            ST_P_N:   if (i_mul_rsp.done) r_b <= prod;
            ST_P_DIV: if (i_div_rsp.done) r_a <= i_div_rsp.value;
            ST_P_Q9:  if (i_mul_rsp.done) r_b <= prod;
            ST_P_Q9B: if (i_mul_rsp.done) r_b <= $signed(prod) >>> 25;
            ST_P_Q8:  if (i_mul_rsp.done) r_c <= $signed(prod) >>> 19;
            ST_P_FIN: r_press <= 32'(($signed(fin_sum) >>> 8) + (sx16(i_ph[47:32]) << 4));
            default:  r_op <= r_op;
        endcase
    end

    assign o_idle            = (r_state == ST_IDLE);
    assign o_res.valid       = (r_state == ST_OUT);
    assign o_res.is_pressure = r_op;
    assign o_res.temperature = r_temp;
    assign o_res.pressure    = r_press;
    assign o_res.div_zero    = r_dz;

endmodule

`default_nettype wire

/* hw/rtl/baro_temp_pressure_compensate.sv */
// Channel   | Direction | Handshake          | Payload
// input     | in        | i_valid / o_stall  | i_op, i_raw_sample
// result    | out       | o_valid / i_stall  | o_is_pressure, o_temperature_centi,
//           |           |                    | o_pressure_q24_8, o_div_zero
// config    | in        | i_cfg_wr_en        | i_cfg_index, i_cfg_data
//
// From acceptance to a valid result, a temperature beat runs three passes
// through the shared multiplier plus a finishing step. A pressure beat runs
// ten multiplier passes, one division, a setup step, a divisor check and a
// finishing step, all run one after the other by the sequencer. With a zero
// divisor the result is ready once the divisor check is done, skipping the rest.
// The input is stalled whenever the sequencer is not idle; the finished
// result sits in the output register, so a stalled result does not block
// the next sample from being computed up to its own output step.
// Synchronous active-low reset clears the coefficients, the stored fine
// temperature and all handshake state.
//
// Top level of the barometric compensation block. Depends on btpc_pkg,
// btpc_mul, btpc_div and btpc_seq.
`timescale 1ns / 1ps
`default_nettype none

module baro_temp_pressure_compensate
    import btpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Sample channel.
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_op,
    input  wire logic [RAW_W-1:0]     i_raw_sample,
    // Result channel.
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_is_pressure,
    output logic signed [31:0]        o_temperature_centi,
    output logic [31:0]               o_pressure_q24_8,
    output logic                      o_div_zero,
    // Coefficient write port.
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    // Calibration coefficients: write only while the block is idle (not enforced).
    logic [47:0] r_tc;
    logic [63:0] r_pl;
    logic [63:0] r_ph;
    logic [15:0] r_p9;

    // Output register.
    logic        r_o_valid;
    logic        r_o_is_p;
    logic [31:0] r_o_temp;
    logic [31:0] r_o_press;
    logic        r_o_dz;

    logic      seq_idle;
    logic      accept;
    logic      load;
    t_unit_req mul_req;
    t_unit_rsp mul_rsp;
    t_unit_req div_req;
    t_unit_rsp div_rsp;
    t_result   res;

    assign accept = i_valid && seq_idle;
    // The output register takes a result when it is empty or being drained.
    assign load   = res.valid && (!r_o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= 48'd0;
            r_pl <= 64'd0;
            r_ph <= 64'd0;
            r_p9 <= 16'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TEMP_COEFFS: r_tc <= i_cfg_data[47:0];
                CFG_PRESS_LOW:   r_pl <= i_cfg_data;
                CFG_PRESS_HIGH:  r_ph <= i_cfg_data;
                CFG_PRESS_NINE:  r_p9 <= i_cfg_data[15:0];
                default:         r_p9 <= r_p9;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_is_p  <= res.is_pressure;
            r_o_temp  <= res.temperature;
            r_o_press <= res.pressure;
            r_o_dz    <= res.div_zero;
        end
    end

    btpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    btpc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_raw       (i_raw_sample),
        .i_tc        (r_tc),
        .i_pl        (r_pl),
        .i_ph        (r_ph),
        .i_p9        (r_p9),
        .i_res_taken (load),
        .o_idle      (seq_idle),
        .o_mul_req   (mul_req),
        .i_mul_rsp   (mul_rsp),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_res       (res)
    );

    assign o_stall             = !seq_idle;
    assign o_valid             = r_o_valid;
    assign o_is_pressure       = r_o_is_p;
    assign o_temperature_centi = r_o_temp;
    assign o_pressure_q24_8    = r_o_press;
    assign o_div_zero          = r_o_dz;

endmodule

`default_nettype wire

/* hw/rtl/btpc_checker.sv */
// Port-level checker for the barometric compensation block, bound to the
// top level. Depends on assert_macros.svh and btpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btpc_checker
    import btpc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_is_pressure,
    input wire logic [31:0] o_temperature_centi,
    input wire logic [31:0] o_pressure_q24_8,
    input wire logic        o_div_zero
);

    `BTPC_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid)
    `BTPC_ASSERT(a_busy_after_accept, i_valid && !o_stall |=> o_stall)
    `BTPC_ASSERT_MSG(a_temp_clean,
        o_valid && !o_is_pressure |-> o_pressure_q24_8 == 32'd0 && !o_div_zero,
        "temperature beat carries pressure data")
    `BTPC_ASSERT_MSG(a_dz_clean,
        o_valid && o_div_zero |-> o_is_pressure && o_pressure_q24_8 == 32'd0
            && o_temperature_centi == 32'd0,
        "divide-by-zero beat carries data")

endmodule

bind baro_temp_pressure_compensate btpc_checker u_btpc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_is_pressure       (o_is_pressure),
    .o_temperature_centi (o_temperature_centi),
    .o_pressure_q24_8    (o_pressure_q24_8),
    .o_div_zero          (o_div_zero)
);

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for baro_temp_pressure_compensate: it drives
// temperature and pressure samples, predicts each result and compares it.
// Depends on btpc_pkg and the block's RTL.
`timescale 1ns / 1ps

class comp_scoreboard;
    logic [47:0] temp_c;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_nine;
    logic [31:0] fine_t;
    logic [65:0] expected_q[$];  // {is_pressure, temp, press, div_zero}
    int errors;

    function new();
        temp_c = '0;
        press_lo = '0;
        press_hi = '0;
        press_nine = '0;
        fine_t = '0;
        errors = 0;
    endfunction

    function void set_coeff(logic [1:0] idx, logic [63:0] val);
        case (idx)
            btpc_pkg::CFG_TEMP_COEFFS: temp_c = val[47:0];
            btpc_pkg::CFG_PRESS_LOW:   press_lo = val;
            btpc_pkg::CFG_PRESS_HIGH:  press_hi = val;
            btpc_pkg::CFG_PRESS_NINE:  press_nine = val[15:0];
            default: ;
        endcase
    endfunction

    function logic signed [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function logic signed [31:0] temp_centi(logic [19:0] adc);
        logic signed [31:0] t1, t2, t3, d1, d2, a, b;
        t1 = {16'd0, temp_c[15:0]};
        t2 = {{16{temp_c[31]}}, temp_c[31:16]};
        t3 = {{16{temp_c[47]}}, temp_c[47:32]};
        d1 = $signed({15'd0, adc[19:3]}) - (t1 <<< 1);
        a = (d1 * t2) >>> 11;
        d2 = $signed({16'd0, adc[19:4]}) - t1;
        b = (((d2 * d2) >>> 12) * t3) >>> 14;
        fine_t = a + b;
        return ($signed(fine_t) * 5 + 128) >>> 8;
    endfunction

    function logic [32:0] pressure(logic [19:0] adc);  // {div_zero, value}
        logic signed [63:0] v1, v2, p, q, ph;
        logic [63:0] un, ud;
        v1 = $signed({{32{fine_t[31]}}, fine_t}) - 64'sd128000;
        v2 = v1 * v1 * sx16(press_hi[31:16]);
        v2 = v2 + ((v1 * sx16(press_hi[15:0])) <<< 17);
        v2 = v2 + (sx16(press_lo[63:48]) <<< 35);
        v1 = ((v1 * v1 * sx16(press_lo[47:32])) >>> 8)
            + ((v1 * sx16(press_lo[31:16])) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * $signed({48'd0, press_lo[15:0]})) >>> 33;
        if (v1 == 0) return {1'b1, 32'd0};
        p = 64'sd1048576 - $signed({44'd0, adc});
        p = ((p <<< 31) - v2) * 64'sd3125;
        // Signed division truncating toward zero, done on magnitudes so the
        // most negative dividend over -1 wraps.
        un = p[63] ? -p : p;
        ud = v1[63] ? -v1 : v1;
        q = un / ud;
        if (p[63] != v1[63]) q = -q;
        ph = q >>> 13;
        v1 = (sx16(press_nine) * ph * ph) >>> 25;
        v2 = (sx16(press_hi[63:48]) * q) >>> 19;
        p = ((q + v1 + v2) >>> 8) + (sx16(press_hi[47:32]) <<< 4);
        return {1'b0, p[31:0]};
    endfunction

    function void note_sample(logic op, logic [19:0] adc);
        logic [32:0] pr;
        if (!op) begin
            expected_q.push_back({1'b0, temp_centi(adc), 32'd0, 1'b0});
        end else begin
            pr = pressure(adc);
            expected_q.push_back({1'b1, 32'd0, pr[31:0], pr[32]});
        end
    endfunction

    function int check_result(logic isp, logic [31:0] t, logic [31:0] p, logic dz);
        logic [65:0] e;
        if (expected_q.size() == 0) return 1;
        e = expected_q.pop_front();
        if (e[65] !== isp) return 2;
        if (e[64:33] !== t) return 3;
        if (e[32:1] !== p) return 4;
        if (e[0] !== dz) return 5;
        return 0;
    endfunction
endclass

module tb_top;
    import btpc_pkg::*;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, i_op;
    logic [RAW_W-1:0] i_raw_sample;
    logic o_valid, i_stall, o_is_pressure, o_div_zero;
    logic signed [31:0] o_temperature_centi;
    logic [31:0] o_pressure_q24_8;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;

    comp_scoreboard sb;
    int mismatches;
    int send_idle_pct;
    int stall_pct;
    logic hold_off;

    baro_temp_pressure_compensate u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The run may not go past this point; a slow correct run needs well under
    // half of it.
    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Result side: stall at random, and for the whole hold-off when asked, so
    // that the block backs up and stalls its own input.
    always @(posedge i_clk) begin
        int code;
        if (i_rst_n && o_valid && !i_stall) begin
            code = sb.check_result(o_is_pressure, o_temperature_centi,
                                   o_pressure_q24_8, o_div_zero);
            case (code)
                0: ;
                1: report_mismatch("result with nothing expected");
                2: report_mismatch("is_pressure");
                3: report_mismatch("temperature_centi");
                4: report_mismatch("pressure_q24_8");
                default: report_mismatch("div_zero");
            endcase
        end
        i_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // One write beat, then the enable drops before the next driver action.
    task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        sb.set_coeff(idx, val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one beat and holds it until the block takes it. Valid stays high
    // afterwards so a following beat can go out with no gap; idle cycles and
    // the drain drop it.
    task automatic send_sample(input logic op, input logic [19:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_raw_sample <= raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_sample(op, raw);
    endtask

    // Waits until every expected result came back, plus the pressure latency
    // so nothing is still in flight before a coefficient write.
    task automatic drain;
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Realistic coefficients with random jitter, so most results land in a
    // meaningful range while every bit still toggles somewhere in the run.
    task automatic load_typical;
        write_coeff(CFG_TEMP_COEFFS, {16'($urandom_range(0, 65535) - 32768 + 50),
                                      16'(26000 + $urandom_range(2000)),
                                      16'(27000 + $urandom_range(2000))});
        write_coeff(CFG_PRESS_LOW, {16'(2800 + $urandom_range(200)),
                                    16'(4000 + $urandom_range(1000)),
                                    16'(-10000 - $urandom_range(2000)),
                                    16'(36000 + $urandom_range(2000))});
        write_coeff(CFG_PRESS_HIGH, {16'($urandom_range(65535)),
                                     16'(15500 + $urandom_range(100)),
                                     16'(-7),
                                     16'(140 + $urandom_range(10))});
        write_coeff(CFG_PRESS_NINE, 16'($urandom_range(65535)));
    endtask

    task automatic random_phase(input int n, input int sidle, input int rstall);
        send_idle_pct = sidle;
        stall_pct = rstall;
        repeat (n) send_sample($urandom_range(1), 20'($urandom));
        drain();
    endtask

    initial begin
        sb = new();
        mismatches = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = 1'b0;
        i_raw_sample = '0;
        i_stall = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset coefficients give a zero divisor; pressure before
        // any temperature uses fine temperature zero.
        send_sample(1'b1, 20'd0);
        send_sample(1'b0, 20'hFFFFF);
        send_sample(1'b1, 20'hFFFFF);
        drain();
        load_typical();
        send_sample(1'b1, 20'd415148);
        send_sample(1'b0, 20'd519888);
        send_sample(1'b1, 20'd415148);
        send_sample(1'b0, 20'd0);
        send_sample(1'b1, 20'd0);
        send_sample(1'b0, 20'hFFFFF);
        send_sample(1'b1, 20'hFFFFF);
        drain();
        // Extreme coefficients: all ones and the most negative values force
        // wrapping in both paths.
        write_coeff(CFG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_coeff(CFG_PRESS_LOW, '1);
        write_coeff(CFG_PRESS_HIGH, '1);
        write_coeff(CFG_PRESS_NINE, 64'h7FFF);
        send_sample(1'b0, 20'hFFFFF);
        send_sample(1'b1, 20'hFFFFF);
        send_sample(1'b1, 20'd0);
        drain();
        write_coeff(CFG_TEMP_COEFFS, 64'h8000_8000_0000);
        write_coeff(CFG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
        write_coeff(CFG_PRESS_HIGH, 64'h8000_8000_8000_8000);
        write_coeff(CFG_PRESS_NINE, 64'h8000);
        send_sample(1'b0, 20'd0);
        send_sample(1'b1, 20'd12345);
        send_sample(1'b0, 20'hFFFFF);
        send_sample(1'b1, 20'hFFFFF);
        drain();

        // Random, realistic coefficients across the idling phases.
        load_typical();
        random_phase(130, 0, 0);
        load_typical();
        random_phase(100, 66, 0);
        // Long receiver hold-off, counted in its own process, while the
        // sender keeps offering beats.
        fork
            begin
                hold_off <= 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        random_phase(100, 0, 66);
        load_typical();
        random_phase(100, 12, 12);
        // Fully random coefficients hit the odd corners and zero divisors.
        write_coeff(CFG_TEMP_COEFFS, {$urandom, $urandom});
        write_coeff(CFG_PRESS_LOW, {$urandom, $urandom});
        write_coeff(CFG_PRESS_HIGH, {$urandom, $urandom});
        write_coeff(CFG_PRESS_NINE, {$urandom, $urandom});
        random_phase(100, 30, 30);

        if (mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
